@@ hw/rtl/ljas_pkg.sv @@
// shared constants, types and the squaring table for the lfsr jump-ahead seed block
package ljas_pkg;

   localparam int unsigned LFSR_WIDTH = 64;
   localparam int unsigned BIT_IDX_WIDTH = 6;

   // feedback polynomial and period of the 64-bit galois lfsr
   localparam logic [LFSR_WIDTH-1:0] POLY = 64'h0000_0000_0000_0007;
   localparam logic signed [LFSR_WIDTH-1:0] PERIOD = 64'sd1317624576693539401;
   localparam logic signed [LFSR_WIDTH-1:0] NEG_PERIOD = -PERIOD;

   // start value: the state after zero steps, which also begins the walk
   localparam logic [LFSR_WIDTH-1:0] LFSR_ONE = 64'h1;

   // count bit the walk starts from; range reduction leaves no count bit above it set
   localparam logic [BIT_IDX_WIDTH-1:0] TOP_BIT = 6'd62;

   typedef logic [LFSR_WIDTH-1:0][LFSR_WIDTH-1:0] sq_table_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_DONE
   } state_type;

   // one lfsr step
   function automatic logic [LFSR_WIDTH-1:0] lfsr_advance(input logic [LFSR_WIDTH-1:0] x);
      return {x[LFSR_WIDTH-2:0], 1'b0} ^ (x[LFSR_WIDTH-1] ? POLY : '0);
   endfunction

   // entry j holds x^(2j) mod poly
   function automatic sq_table_type build_squares();
      sq_table_type tbl;
      logic [LFSR_WIDTH-1:0] t;
      t = LFSR_ONE;
      for (int j = 0; j < LFSR_WIDTH; j++) begin
         tbl[j] = t;
         t = lfsr_advance(lfsr_advance(t));
      end
      return tbl;
   endfunction

   localparam sq_table_type SQ_TABLE = build_squares();

endpackage

@@ hw/rtl/ljas_sqstep.sv @@
// square-and-step unit: squares the lfsr state mod poly, then optionally steps it
module ljas_sqstep
   import ljas_pkg::*;
(
   input  logic [LFSR_WIDTH-1:0] value_in,
   input  logic                  step_en,
   output logic [LFSR_WIDTH-1:0] value_out
);

   logic [LFSR_WIDTH-1:0] squared;

   // squaring is linear over gf(2): xor the table rows picked by the set bits
   always_comb begin
      squared = '0;
      for (int j = 0; j < LFSR_WIDTH; j++) begin
         if (value_in[j]) begin
            squared = squared ^ SQ_TABLE[j];
         end
      end
   end

   // one lfsr step when the current count bit is set
   assign value_out = step_en ? lfsr_advance(squared) : squared;

endmodule

@@ hw/rtl/lfsr_jump_ahead_seed.sv @@
// top level of the lfsr jump-ahead seed generator
//
//   channel   ports                         direction  transfer
//   request   start, busy, req_step_count   in         start high while busy low
//   response  rsp_valid, rsp_lfsr_value     out        rsp_valid high, one cycle
//
// the count is first brought into range, one add or subtract of the period per
// cycle, then the square-and-step unit walks count bits 62 down to 0, one bit
// per cycle, and the done state presents the result. busy is high while the
// sequencer is out of idle: it rises once the transfer is registered and stays
// high through the response cycle. reset returns the sequencer to idle; the
// response cannot be stalled.
module lfsr_jump_ahead_seed
   import ljas_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [LFSR_WIDTH-1:0] req_step_count,
   output logic                         rsp_valid,
   output logic        [LFSR_WIDTH-1:0] rsp_lfsr_value
);

   state_type state_ff, state_in;

   logic signed [LFSR_WIDTH-1:0]    count_ff, count_in;
   logic        [LFSR_WIDTH-1:0]    value_ff, value_in;
   logic        [BIT_IDX_WIDTH-1:0] bit_idx_ff, bit_idx_in;

   logic signed [LFSR_WIDTH-1:0] reduce_sum;
   logic                         count_neg;
   logic                         count_above;
   logic                         accept;
   logic [LFSR_WIDTH-1:0]        sq_value;

   assign accept = start && (state_ff == ST_IDLE);

   // shared adder for range reduction: add the period while negative, else subtract
   assign count_neg   = count_ff[LFSR_WIDTH-1];
   assign reduce_sum  = count_ff + (count_neg ? PERIOD : NEG_PERIOD);
   assign count_above = !reduce_sum[LFSR_WIDTH-1] && (reduce_sum != '0);

   ljas_sqstep u_sqstep (
      .value_in  (value_ff),
      .step_en   (count_ff[bit_idx_ff]),
      .value_out (sq_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!count_neg && !count_above) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (bit_idx_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      count_in   = count_ff;
      value_in   = value_ff;
      bit_idx_in = bit_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = req_step_count;
            end
         end
         ST_REDUCE: begin
            if (count_neg || count_above) begin
               count_in = reduce_sum;
            end else begin
               // leading zeros keep the value at one, the top set bit makes it two
               value_in   = LFSR_ONE;
               bit_idx_in = TOP_BIT;
            end
         end
         ST_SQUARE: begin
            value_in   = sq_value;
            bit_idx_in = bit_idx_ff - 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
   end

   assign rsp_lfsr_value = value_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      value_ff   <= value_in;
      bit_idx_ff <= bit_idx_in;
   end

`ifndef SYNTHESIS
   // a response is only ever shown while the block is busy
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while not busy");

   // an accepted request makes the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request transfer did not start the sequencer");

   // the block frees up right after the response
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy stayed high after the response");

   // the square-and-step walk only starts once the count is in range
   a_square_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE && state_in == ST_SQUARE) |->
         (!count_ff[LFSR_WIDTH-1] && count_ff[LFSR_WIDTH-1:LFSR_WIDTH-2] == 2'b00))
      else $error("count out of range at start of the walk");
`endif

endmodule

@@ tb/lfsr_jump_ahead_seed_tb.sv @@
// self-checking testbench for the lfsr jump-ahead seed generator
module lfsr_jump_ahead_seed_tb
   import ljas_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [LFSR_WIDTH-1:0] req_step_count = '0;
   logic                         rsp_valid;
   logic        [LFSR_WIDTH-1:0] rsp_lfsr_value;

   logic [LFSR_WIDTH-1:0] expected_lfsr_q[$];
   int unsigned           mismatch_count = 0;
   int unsigned           transfer_count = 0;
   bit                    no_idle_run = 1'b0;

   lfsr_jump_ahead_seed dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_step_count (req_step_count),
      .rsp_valid      (rsp_valid),
      .rsp_lfsr_value (rsp_lfsr_value)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // multiply by x modulo x^64 + x^2 + x + 1
   function automatic logic [LFSR_WIDTH-1:0] gf_times_x(input logic [LFSR_WIDTH-1:0] v);
      return (v << 1) ^ ({LFSR_WIDTH{v[LFSR_WIDTH-1]}} & POLY);
   endfunction

   // carry-less square, then fold the upper half back down
   function automatic logic [LFSR_WIDTH-1:0] gf_square(input logic [LFSR_WIDTH-1:0] v);
      logic [2*LFSR_WIDTH-1:0] wide;
      wide = '0;
      for (int i = 0; i < LFSR_WIDTH; i++)
         wide[2*i] = v[i];
      for (int i = 2*LFSR_WIDTH-1; i >= LFSR_WIDTH; i--) begin
         if (wide[i]) begin
            wide[i] = 1'b0;
            wide[i-LFSR_WIDTH +: 3] ^= 3'b111;
         end
      end
      return wide[LFSR_WIDTH-1:0];
   endfunction

   // x^n mod poly for the range-reduced step count
   function automatic logic [LFSR_WIDTH-1:0] expected_lfsr_value(input longint count);
      longint                n;
      longint                period;
      logic [LFSR_WIDTH-1:0] v;
      int                    top;
      period = longint'(PERIOD);
      n = count;
      while (n < 0)
         n += period;
      while (n > period)
         n -= period;
      if (n == 0)
         return LFSR_ONE;
      top = 62;
      while (top > 0 && !n[top])
         top--;
      v = 64'h2;
      for (int b = top - 1; b >= 0; b--) begin
         v = gf_square(v);
         if (n[b])
            v = gf_times_x(v);
      end
      return v;
   endfunction

   // one request transfer, with an optional wait for idle and a random gap before it
   task automatic send_count(input longint count);
      int unsigned gap;
      bit          wait_idle;
      gap = no_idle_run ? 0 : $urandom_range(0, 19);
      wait_idle = no_idle_run ? 1'b0 : 1'($urandom_range(0, 1));
      if (wait_idle || gap != 0) begin
         start <= 1'b0;
         if (wait_idle) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_step_count <= count;
      do @(posedge clock); while (busy);
      expected_lfsr_q.push_back(expected_lfsr_value(count));
      transfer_count++;
      if (transfer_count % 64 == 0)
         no_idle_run = ($urandom_range(0, 3) == 0);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_lfsr_q.size() == 0) begin
            $error("lfsr_value: no transfer expected, actual %h", rsp_lfsr_value);
            mismatch_count++;
         end else begin
            logic [LFSR_WIDTH-1:0] want;
            want = expected_lfsr_q.pop_front();
            if (rsp_lfsr_value !== want) begin
               $error("lfsr_value: expected %h, actual %h", want, rsp_lfsr_value);
               mismatch_count++;
            end
         end
      end
   end

   // extremes, zero, period boundaries and sign cases
   task automatic test_directed();
      longint p = longint'(PERIOD);
      longint counts[$];
      counts = '{0, 1, 2, 3, -1, -2, 63, 64, 65, p, p - 1, p + 1, -p, -p + 1,
                 2 * p, -2 * p, 7 * p, 64'sh7fff_ffff_ffff_ffff,
                 64'sh8000_0000_0000_0000, 64'sh4000_0000_0000_0000,
                 64'sh3fff_ffff_ffff_ffff, 64'sh5555_5555_5555_5555,
                 64'shaaaa_aaaa_aaaa_aaaa};
      foreach (counts[i])
         send_count(counts[i]);
   endtask

   // short jumps in both directions
   task automatic test_small_counts(input int unsigned num);
      longint c;
      repeat (num) begin
         c = longint'($urandom_range(0, 200));
         send_count($urandom_range(0, 1) ? -c : c);
      end
   endtask

   // counts close to multiples of the period, wrapping at the ends
   task automatic test_period_multiples(input int unsigned num);
      longint k;
      longint delta;
      repeat (num) begin
         k = longint'($urandom_range(0, 14)) - 7;
         delta = longint'($urandom_range(0, 6)) - 3;
         send_count(k * longint'(PERIOD) + delta);
      end
   endtask

   // any 64-bit count
   task automatic test_full_range(input int unsigned num);
      repeat (num)
         send_count(longint'({$urandom, $urandom}));
   endtask

   // counts already inside 0 .. period
   task automatic test_reduced_range(input int unsigned num);
      logic [LFSR_WIDTH-1:0] u;
      repeat (num) begin
         u = {$urandom, $urandom};
         send_count(longint'(u % (PERIOD + 64'd1)));
      end
   endtask

   // counts of every bit length, either sign
   task automatic test_bit_lengths(input int unsigned num);
      logic [LFSR_WIDTH-1:0] u;
      int unsigned           w;
      repeat (num) begin
         w = $urandom_range(1, LFSR_WIDTH);
         u = {$urandom, $urandom} >> (LFSR_WIDTH - w);
         u[w-1] = 1'b1;
         send_count($urandom_range(0, 1) ? -longint'(u) : longint'(u));
      end
   endtask

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_small_counts(200);
      test_period_multiples(300);
      test_full_range(500);
      test_reduced_range(400);
      test_bit_lengths(300);
      start <= 1'b0;
      while (expected_lfsr_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ljas_pkg.sv
hw/rtl/ljas_sqstep.sv
hw/rtl/lfsr_jump_ahead_seed.sv
tb/lfsr_jump_ahead_seed_tb.sv
